>>> rtl/mevs_pkg.sv
// Shared constants, types and helper functions for the multi-encoding value scan block.
`timescale 1ns / 1ps
package mevs_pkg;

   // Address handling
   localparam int ADDR_BITS_DEF = 48;
   localparam int FIELD_ADDR_W  = 48;
   localparam logic [2:0] ALIGN8_MASK = 3'd7;

   // Target register width
   localparam int TARGET_W = 54;

   // Encodings
   localparam int ENC_COUNT = 6;
   localparam int ENC_W     = 3;

   typedef enum logic [ENC_W-1:0] {
      ENC_I32  = 3'd0,
      ENC_I64  = 3'd1,
      ENC_F32  = 3'd2,
      ENC_F64  = 3'd3,
      ENC_K32  = 3'd4,
      ENC_K64  = 3'd5
   } enc_type;

   // Operation codes
   localparam logic OP_SCAN   = 1'b0;
   localparam logic OP_REFINE = 1'b1;

   // Scaled-range constants
   localparam logic [9:0] KILO      = 10'd1000;
   localparam logic [9:0] KILO_SPAN = 10'd999;

   // Bound derivation sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SH32,
      ST_SH16,
      ST_SH8,
      ST_SH4,
      ST_SH2,
      ST_SH1,
      ST_PACK
   } cfg_state_type;

   // Values derived from the target, held steady while items flow
   typedef struct packed {
      logic [31:0] t_low32;
      logic [63:0] t_ext;
      logic        kilo_ok;
      logic [62:0] kilo_lo;
      logic [63:0] kilo_hi;
      logic [31:0] f32_lo_key;
      logic [31:0] f32_hi_key;
      logic [63:0] f64_lo_key;
      logic [63:0] f64_hi_key;
   } bounds_type;

   // Order-preserving key of an f32 pattern; both zeros map to the same key
   function automatic logic [31:0] f32_key(input logic [31:0] b);
      logic [31:0] k;
      if (b[30:0] == '0) begin
         k = 32'h8000_0000;
      end else if (b[31]) begin
         k = ~b;
      end else begin
         k = b | 32'h8000_0000;
      end
      return k;
   endfunction

   // Order-preserving key of an f64 pattern; both zeros map to the same key
   function automatic logic [63:0] f64_key(input logic [63:0] b);
      logic [63:0] k;
      if (b[62:0] == '0) begin
         k = 64'h8000_0000_0000_0000;
      end else if (b[63]) begin
         k = ~b;
      end else begin
         k = b | 64'h8000_0000_0000_0000;
      end
      return k;
   endfunction

endpackage

>>> rtl/mevs_if.sv
// Valid/ready channel interfaces for window requests and match responses.
`timescale 1ns / 1ps
interface mevs_req_if;
   logic                              valid;
   logic                              ready;
   logic                              operation;
   logic [mevs_pkg::FIELD_ADDR_W-1:0] scan_addr;
   logic [31:0]                       window_low;
   logic [31:0]                       window_high;
   logic [mevs_pkg::ENC_W-1:0]        check_encoding;

   modport source (output valid, operation, scan_addr, window_low, window_high,
                   check_encoding, input ready);
   modport sink   (input valid, operation, scan_addr, window_low, window_high,
                   check_encoding, output ready);
endinterface

interface mevs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mevs_pkg::FIELD_ADDR_W-1:0] match_addr;
   logic [mevs_pkg::ENC_W-1:0]        match_encoding;
   logic                              last_match;

   modport source (output valid, match_addr, match_encoding, last_match, input ready);
   modport sink   (input valid, match_addr, match_encoding, last_match, output ready);
endinterface

>>> rtl/mevs_cfg.sv
// Target register and sequencer that derives the compare bounds from it.
`timescale 1ns / 1ps
module mevs_cfg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic signed [mevs_pkg::TARGET_W-1:0] csr_wdata,
   output logic                                 busy,
   output mevs_pkg::bounds_type                 bounds
);
   import mevs_pkg::*;

   cfg_state_type state_ff, state_in;

   logic [TARGET_W-1:0] target_ff;
   logic                neg_ff;
   logic [63:0]         xa_ff, xb_ff;
   logic [5:0]          ea_ff, eb_ff;
   logic                za_ff, zb_ff;
   logic                kilo_ok_ff;
   logic [62:0]         kilo_lo_ff;
   logic [63:0]         kilo_hi_ff;
   logic [31:0]         f32_lo_key_ff, f32_hi_key_ff;
   logic [63:0]         f64_lo_key_ff, f64_hi_key_ff;

   logic [TARGET_W-1:0] mag, mag1;
   logic [5:0]          sh;
   logic [63:0]         top_mask;
   logic                a_top_zero, b_top_zero;

   // Round a normalised magnitude to 53 bits and pack as f64
   function automatic logic [63:0] pack_f64(input logic s, input logic z,
                                            input logic [63:0] x, input logic [5:0] e);
      logic        rup;
      logic [53:0] r;
      logic [10:0] ex;
      logic [63:0] res;
      rup = x[10] & ((|x[9:0]) | x[11]);
      r   = {1'b0, x[63:11]} + 54'(rup);
      ex  = 11'(e) + 11'd1023 + 11'(r[53]);
      if (z) begin
         res = '0;
      end else begin
         res = {s, ex, (r[53] ? 52'd0 : r[51:0])};
      end
      return res;
   endfunction

   // Round a normalised magnitude to 24 bits and pack as f32
   function automatic logic [31:0] pack_f32(input logic s, input logic z,
                                            input logic [63:0] x, input logic [5:0] e);
      logic        rup;
      logic [24:0] r;
      logic [7:0]  ex;
      logic [31:0] res;
      rup = x[39] & ((|x[38:0]) | x[40]);
      r   = {1'b0, x[63:40]} + 25'(rup);
      ex  = 8'(e) + 8'd127 + 8'(r[24]);
      if (z) begin
         res = '0;
      end else begin
         res = {s, ex, (r[24] ? 23'd0 : r[22:0])};
      end
      return res;
   endfunction

   // Magnitudes of the two bounds
   always_comb begin
      mag  = target_ff[TARGET_W-1] ? (~target_ff + 1'b1) : target_ff;
      mag1 = target_ff[TARGET_W-1] ? (mag - 1'b1) : (mag + 1'b1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = ST_LOAD;
      end else begin
         case (state_ff)
            ST_IDLE: state_in = ST_IDLE;
            ST_LOAD: state_in = ST_SH32;
            ST_SH32: state_in = ST_SH16;
            ST_SH16: state_in = ST_SH8;
            ST_SH8:  state_in = ST_SH4;
            ST_SH4:  state_in = ST_SH2;
            ST_SH2:  state_in = ST_SH1;
            ST_SH1:  state_in = ST_PACK;
            ST_PACK: state_in = ST_IDLE;
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // Outputs of the sequencer: busy flag and normalise shift
   always_comb begin
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_SH32: sh = 6'd32;
         ST_SH16: sh = 6'd16;
         ST_SH8:  sh = 6'd8;
         ST_SH4:  sh = 6'd4;
         ST_SH2:  sh = 6'd2;
         ST_SH1:  sh = 6'd1;
         default: sh = 6'd0;
      endcase
   end

   always_comb begin
      top_mask   = ~({64{1'b1}} >> sh);
      a_top_zero = ((xa_ff & top_mask) == '0);
      b_top_zero = ((xb_ff & top_mask) == '0);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         target_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            target_ff <= csr_wdata;
         end
      end
   end

   // Derivation datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            neg_ff     <= target_ff[TARGET_W-1];
            xa_ff      <= 64'(mag);
            xb_ff      <= 64'(mag1);
            ea_ff      <= 6'd63;
            eb_ff      <= 6'd63;
            za_ff      <= (mag == '0);
            zb_ff      <= (mag1 == '0);
            kilo_ok_ff <= ~target_ff[TARGET_W-1];
            // 1000 t = 1024 t - 16 t - 8 t
            kilo_lo_ff <= {target_ff[52:0], 10'd0} - 63'({target_ff[52:0], 4'd0})
                          - 63'({target_ff[52:0], 3'd0});
         end
         ST_SH32, ST_SH16, ST_SH8, ST_SH4, ST_SH2, ST_SH1: begin
            if (state_ff == ST_SH32) begin
               kilo_hi_ff <= 64'(kilo_lo_ff) + 64'(KILO_SPAN);
            end
            if (a_top_zero) begin
               xa_ff <= xa_ff << sh;
               ea_ff <= ea_ff - sh;
            end
            if (b_top_zero) begin
               xb_ff <= xb_ff << sh;
               eb_ff <= eb_ff - sh;
            end
         end
         ST_PACK: begin
            f32_lo_key_ff <= f32_key(pack_f32(neg_ff, za_ff, xa_ff, ea_ff));
            f32_hi_key_ff <= f32_key(pack_f32(neg_ff & ~zb_ff, zb_ff, xb_ff, eb_ff));
            f64_lo_key_ff <= f64_key(pack_f64(neg_ff, za_ff, xa_ff, ea_ff));
            f64_hi_key_ff <= f64_key(pack_f64(neg_ff & ~zb_ff, zb_ff, xb_ff, eb_ff));
         end
         default: begin
         end
      endcase
   end

   // Bundle for the compare stage
   always_comb begin
      bounds.t_low32    = target_ff[31:0];
      bounds.t_ext      = {{(64-TARGET_W){target_ff[TARGET_W-1]}}, target_ff};
      bounds.kilo_ok    = kilo_ok_ff;
      bounds.kilo_lo    = kilo_lo_ff;
      bounds.kilo_hi    = kilo_hi_ff;
      bounds.f32_lo_key = f32_lo_key_ff;
      bounds.f32_hi_key = f32_hi_key_ff;
      bounds.f64_lo_key = f64_lo_key_ff;
      bounds.f64_hi_key = f64_hi_key_ff;
   end

endmodule

>>> rtl/mevs_match.sv
// Input register and the six encoding compares, giving a match mask per window.
`timescale 1ns / 1ps
module mevs_match #(
   parameter int KEPT_W = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       busy,
   input  mevs_pkg::bounds_type       bounds,
   mevs_req_if.sink                   req_chan,
   input  logic                       emit_free,
   output logic                       emit_load,
   output logic [mevs_pkg::ENC_COUNT-1:0] emit_mask,
   output logic [KEPT_W-1:0]          emit_addr
);
   import mevs_pkg::*;

   logic              s1_valid_ff;
   logic              s1_op_ff;
   logic [KEPT_W-1:0] s1_addr_ff;
   logic [31:0]       s1_lo_ff, s1_hi_ff;
   logic [ENC_W-1:0]  s1_sel_ff;

   logic [63:0]          w;
   logic [31:0]          k32;
   logic [63:0]          k64;
   logic                 al8;
   logic [ENC_COUNT-1:0] hits, gate;

   assign req_chan.ready = ~busy & (~s1_valid_ff | emit_free);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (emit_free) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_op_ff   <= req_chan.operation;
         s1_addr_ff <= req_chan.scan_addr[KEPT_W-1:0];
         s1_lo_ff   <= req_chan.window_low;
         s1_hi_ff   <= req_chan.window_high;
         s1_sel_ff  <= req_chan.check_encoding;
      end
   end

   // Encoding compares
   always_comb begin
      w   = {s1_hi_ff, s1_lo_ff};
      k32 = f32_key(s1_lo_ff);
      k64 = f64_key(w);
      al8 = ((s1_addr_ff[2:0] & ALIGN8_MASK) == 3'd0);

      hits[ENC_I32] = (s1_lo_ff == bounds.t_low32);
      hits[ENC_I64] = (w == bounds.t_ext);
      hits[ENC_F32] = (s1_lo_ff[30:23] != 8'hFF) && (k32 >= bounds.f32_lo_key)
                      && (k32 < bounds.f32_hi_key);
      hits[ENC_F64] = (w[62:52] != 11'h7FF) && (k64 >= bounds.f64_lo_key)
                      && (k64 < bounds.f64_hi_key);
      hits[ENC_K32] = bounds.kilo_ok && !s1_lo_ff[31]
                      && ({32'd0, s1_lo_ff} >= {1'b0, bounds.kilo_lo})
                      && ({32'd0, s1_lo_ff} <= bounds.kilo_hi);
      hits[ENC_K64] = bounds.kilo_ok && !w[63] && (w >= {1'b0, bounds.kilo_lo})
                      && (w <= bounds.kilo_hi);

      // Scan takes every encoding, 64-bit ones only at 8-aligned windows
      if (s1_op_ff == OP_SCAN) begin
         gate = {al8, 1'b1, al8, 1'b1, al8, 1'b1};
      end else if (s1_sel_ff <= ENC_K64) begin
         gate = ENC_COUNT'(1) << s1_sel_ff;
      end else begin
         gate = '0;
      end
   end

   assign emit_load = s1_valid_ff & emit_free;
   assign emit_mask = hits & gate;
   assign emit_addr = s1_addr_ff;

endmodule

>>> rtl/mevs_emit.sv
// Result register that hands out one match per transfer, lowest encoding first.
`timescale 1ns / 1ps
module mevs_emit #(
   parameter int KEPT_W = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           emit_load,
   input  logic [mevs_pkg::ENC_COUNT-1:0] emit_mask,
   input  logic [KEPT_W-1:0]              emit_addr,
   output logic                           emit_free,
   mevs_rsp_if.source                     rsp_chan
);
   import mevs_pkg::*;

   logic [ENC_COUNT-1:0] mask_ff;
   logic [KEPT_W-1:0]    addr_ff;
   logic [ENC_COUNT-1:0] first, rest;
   logic [ENC_W-1:0]     enc;
   logic                 xfer;

   // Pick the lowest pending encoding
   always_comb begin
      first = mask_ff & (~mask_ff + 1'b1);
      rest  = mask_ff & ~first;
      enc   = '0;
      for (int i = 0; i < ENC_COUNT; i++) begin
         if (first[i]) begin
            enc = ENC_W'(i);
         end
      end
   end

   assign xfer      = rsp_chan.valid & rsp_chan.ready;
   assign emit_free = (mask_ff == '0) | (xfer & (rest == '0));

   assign rsp_chan.valid          = (mask_ff != '0);
   assign rsp_chan.match_addr     = FIELD_ADDR_W'(addr_ff);
   assign rsp_chan.match_encoding = enc;
   assign rsp_chan.last_match     = (rest == '0);

   // Pending mask: loaded per window, one bit dropped per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (emit_load) begin
         mask_ff <= emit_mask;
      end else if (xfer) begin
         mask_ff <= rest;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         addr_ff <= emit_addr;
      end
   end

endmodule

>>> rtl/multi_encoding_value_scan_top.sv
// Top level of the multi-encoding value scan block.
//
// req_chan carries one 8-byte memory window per transfer with its address,
// the operation (scan all encodings or refine one) and the encoding code.
// rsp_chan returns one transfer per match, encodings in ascending order;
// last_match marks the final match of a window. A window with no match
// produces nothing on rsp_chan.
// csr_we/csr_wdata write the signed target; after a write the bound sequencer
// steps through its load, shift and pack states with req_chan.ready low,
// then windows flow. An accepted window's match mask is loaded into the result
// register once that register is free. One window per cycle while each window
// gives at most one match and rsp_chan takes it; a window with more matches
// holds the single result register until it drains, one match per transfer.
// Reset clears the pipeline, loads a target of zero and runs the same
// bound sequence before the first window is taken.
// When rsp_chan stalls, the result register holds and the input register
// still takes one more window; ready then drops until the result moves.
`timescale 1ns / 1ps
module multi_encoding_value_scan_top #(
   parameter int ADDR_BITS = mevs_pkg::ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   mevs_req_if.sink                             req_chan,
   mevs_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic signed [mevs_pkg::TARGET_W-1:0] csr_wdata
);
   import mevs_pkg::*;

   localparam int KEPT_W = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;

   bounds_type           bounds;
   logic                 busy;
   logic                 emit_free, emit_load;
   logic [ENC_COUNT-1:0] emit_mask;
   logic [KEPT_W-1:0]    emit_addr;

   mevs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .bounds    (bounds)
   );

   mevs_match #(.KEPT_W(KEPT_W)) u_match (
      .clock     (clock),
      .reset     (reset),
      .busy      (busy),
      .bounds    (bounds),
      .req_chan  (req_chan),
      .emit_free (emit_free),
      .emit_load (emit_load),
      .emit_mask (emit_mask),
      .emit_addr (emit_addr)
   );

   mevs_emit #(.KEPT_W(KEPT_W)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .emit_load (emit_load),
      .emit_mask (emit_mask),
      .emit_addr (emit_addr),
      .emit_free (emit_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> dv/multi_encoding_value_scan_top_tb.sv
// Self-checking testbench for the multi-encoding value scan block.
`timescale 1ns / 1ps
module multi_encoding_value_scan_top_tb;
   import mevs_pkg::*;

   typedef struct packed {
      logic [47:0] addr;
      logic [2:0]  enc;
      logic        last;
   } match_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic signed [TARGET_W-1:0] csr_wdata;

   mevs_req_if req ();
   mevs_rsp_if rsp ();

   multi_encoding_value_scan_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   localparam int WATCHDOG_LIMIT = 5000;

   match_type   expected_matches[$];
   logic [63:0] target_bits;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          mismatches;
   int          quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Float pattern of a signed magnitude, rounded to nearest-even
   function automatic logic [63:0] float_bits(input logic neg, input logic [63:0] mag,
                                              input logic dbl);
      int          prec;
      int          bias;
      int          len;
      int          s;
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] mant;
      logic [63:0] bits;
      prec = dbl ? 53 : 24;
      bias = dbl ? 1023 : 127;
      len = 0;
      for (int i = 0; i < 64; i++) if (mag[i]) len = i + 1;
      if (len > prec) begin
         s = len - prec;
         keep = mag >> s;
         rem = mag & ((64'd1 << s) - 1);
         half = 64'd1 << (s - 1);
         if (rem > half || (rem == half && keep[0])) keep++;
         mag = keep << s;
         len = 0;
         for (int i = 0; i < 64; i++) if (mag[i]) len = i + 1;
      end
      if (mag == 0) begin
         bits = 0;
      end else begin
         mant = (len > prec) ? (mag >> (len - prec)) : (mag << (prec - len));
         bits = (64'(len - 1 + bias) << (prec - 1)) | (mant & ((64'd1 << (prec - 1)) - 1));
      end
      if (neg) bits = bits | (dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000);
      return bits;
   endfunction

   // Signed ordering value of a float pattern; both zeros give 0
   function automatic logic signed [64:0] order_of(input logic [63:0] bits, input logic dbl);
      logic [64:0] m;
      logic        sgn;
      m = dbl ? {2'b0, bits[62:0]} : {34'b0, bits[30:0]};
      sgn = dbl ? bits[63] : bits[31];
      return sgn ? -$signed(m) : $signed(m);
   endfunction

   function automatic bit encoding_matches(input int e, input logic [31:0] lo,
                                           input logic [31:0] hi);
      logic [63:0] w;
      logic        neg;
      logic [63:0] mag;
      logic [63:0] mag1;
      logic [63:0] lo_b;
      logic [63:0] hi_b;
      w = {hi, lo};
      neg = target_bits[63];
      mag = neg ? -target_bits : target_bits;
      mag1 = neg ? mag - 1 : mag + 1;
      case (e)
         ENC_I32: return lo == target_bits[31:0];
         ENC_I64: return w == target_bits;
         ENC_F32: begin
            if (lo[30:23] == 8'hFF) return 0;
            lo_b = float_bits(neg, mag, 1'b0);
            hi_b = float_bits(neg, mag1, 1'b0);
            return order_of({32'b0, lo}, 1'b0) >= order_of(lo_b, 1'b0)
                && order_of({32'b0, lo}, 1'b0) < order_of(hi_b, 1'b0);
         end
         ENC_F64: begin
            if (w[62:52] == 11'h7FF) return 0;
            lo_b = float_bits(neg, mag, 1'b1);
            hi_b = float_bits(neg, mag1, 1'b1);
            return order_of(w, 1'b1) >= order_of(lo_b, 1'b1)
                && order_of(w, 1'b1) < order_of(hi_b, 1'b1);
         end
         ENC_K32: return !lo[31] && !neg && ({32'b0, lo} / 64'd1000) == target_bits;
         ENC_K64: return !w[63] && !neg && (w / 64'd1000) == target_bits;
         default: return 0;
      endcase
   endfunction

   // Queue the matches one accepted window should produce
   task automatic predict_matches(input logic op, input logic [47:0] addr,
                                  input logic [31:0] lo, input logic [31:0] hi,
                                  input logic [2:0] enc);
      match_type found[$];
      match_type m;
      if (op == OP_SCAN) begin
         for (int e = 0; e < ENC_COUNT; e++) begin
            if ((e == ENC_I64 || e == ENC_F64 || e == ENC_K64) && addr[2:0] != 3'd0)
               continue;
            if (encoding_matches(e, lo, hi)) begin
               m.addr = addr; m.enc = 3'(e); m.last = 1'b0;
               found.insert(found.size(), m);
            end
         end
      end else if (encoding_matches(enc, lo, hi)) begin
         m.addr = addr; m.enc = enc; m.last = 1'b0;
         found.insert(found.size(), m);
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) expected_matches.insert(expected_matches.size(), found[i]);
   endtask

   // One window transfer, with an optional gap afterwards
   task automatic send_window(input logic op, input logic [47:0] addr,
                              input logic [31:0] lo, input logic [31:0] hi,
                              input logic [2:0] enc);
      int gap;
      req.valid          <= 1'b1;
      req.operation      <= op;
      req.scan_addr      <= addr;
      req.window_low     <= lo;
      req.window_high    <= hi;
      req.check_encoding <= enc;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_matches(op, addr, lo, hi, enc);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained;
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_matches.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_target(input logic [63:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value[TARGET_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      target_bits = {{(64-TARGET_W){value[TARGET_W-1]}}, value[TARGET_W-1:0]};
   endtask

   // Window built to hit one encoding of the current target, or noise
   task automatic send_random_window;
      logic [47:0] addr;
      logic [63:0] w;
      logic        op;
      logic [2:0]  enc;
      logic [63:0] mag;
      int          kind;
      op = 1'($urandom_range(0, 1));
      addr = 48'({$urandom, $urandom});
      case ($urandom_range(9))
         0, 1, 2, 3, 4: addr[2:0] = 3'd0;
         5, 6, 7, 8:    addr[2:0] = 3'd4;
         default: ;
      endcase
      w = {$urandom, $urandom};
      mag = target_bits[63] ? -target_bits : target_bits;
      kind = $urandom_range(0, 8);
      case (kind)
         ENC_I32: w[31:0] = target_bits[31:0];
         ENC_I64: w = target_bits;
         ENC_F32: w[31:0] = 32'(float_bits(target_bits[63], mag, 1'b0) + $urandom_range(0, 2));
         ENC_F64: w = float_bits(target_bits[63], mag, 1'b1) + $urandom_range(0, 2);
         ENC_K32: w[31:0] = target_bits[31:0] * 1000 + $urandom_range(0, 999);
         ENC_K64: w = target_bits * 1000 + $urandom_range(0, 999);
         6: w[30:20] = 11'h7FF;
         default: ;
      endcase
      enc = (kind < ENC_COUNT && $urandom_range(3) != 0) ? 3'(kind) : 3'($urandom_range(0, 7));
      send_window(op, addr, w[31:0], w[63:32], enc);
   endtask

   // Transfer check on the match channel
   always @(posedge clock) begin
      match_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_matches.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected match: addr %h enc %0d last %0d",
                        rsp.match_addr, rsp.match_encoding, rsp.last_match);
         end else begin
            want = expected_matches.pop_front();
            if (rsp.match_addr !== want.addr || rsp.match_encoding !== want.enc
                || rsp.last_match !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("match mismatch: expected addr %h enc %0d last %0d, got %h %0d %0d",
                           want.addr, want.enc, want.last,
                           rsp.match_addr, rsp.match_encoding, rsp.last_match);
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** multi_encoding_value_scan_top: FAILED **");
         $finish;
      end
   end

   task automatic test_directed_windows;
      logic [47:0] top_addr;
      top_addr = 48'hFFFF_FFFF_FFFC;
      send_idle_pct = 0; recv_stall_pct = 0;
      // target 0: an all-zero window matches every encoding
      send_window(OP_SCAN, 48'h0, 32'h0, 32'h0, 3'd0);
      send_window(OP_SCAN, 48'h4, 32'h0, 32'h0, 3'd0);
      send_window(OP_SCAN, 48'h3, 32'h0, 32'h0, 3'd0);
      send_window(OP_SCAN, top_addr, 32'h0, 32'h0, 3'd7);
      send_window(OP_SCAN, 48'h8, 32'h8000_0000, 32'h8000_0000, 3'd0);
      send_window(OP_SCAN, 48'h10, 32'h7FC0_0000, 32'h7FF8_0000, 3'd0);
      send_window(OP_SCAN, 48'h18, 32'h7F80_0000, 32'h7FF0_0000, 3'd0);
      send_window(OP_SCAN, 48'h20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
      send_window(OP_SCAN, 48'h28, 32'd999, 32'h0, 3'd0);
      send_window(OP_SCAN, 48'h30, 32'h3F00_0000, 32'h3FE0_0000, 3'd0);
      for (int e = 0; e < 8; e++)
         send_window(OP_REFINE, 48'h4, 32'h0, 32'h0, 3'(e));
      send_window(OP_REFINE, top_addr, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
      write_target(64'hFFFF_FFFF_FFFF_FFFF);
      send_window(OP_SCAN, 48'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
      send_window(OP_SCAN, 48'h8, 32'hBF80_0000, 32'hBFF0_0000, 3'd0);
      send_window(OP_SCAN, 48'h10, 32'h8000_0000, 32'h8000_0000, 3'd0);
   endtask

   task automatic test_random_phase(input logic [63:0] value, input int idle_pct,
                                    input int stall_pct, input int count);
      write_target(value);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_random_window();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.operation = OP_SCAN;
      req.scan_addr = '0;
      req.window_low = '0;
      req.window_high = '0;
      req.check_encoding = '0;
      rsp.ready = 1'b0;
      target_bits = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      quiet_cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_windows();
      test_random_phase(64'd0, 0, 0, 40);
      test_random_phase(64'd12345, 78, 0, 40);
      test_random_phase(64'h001F_FFFF_FFFF_FFFF, 0, 78, 40);
      test_random_phase(64'hFFE0_0000_0000_0000, 20, 20, 40);
      test_random_phase({$urandom, $urandom}, 0, 0, 40);
      test_random_phase(64'($urandom_range(0, 5000000)), 78, 78, 40);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_matches.size() == 0) begin
         $display("** multi_encoding_value_scan_top: PASSED **");
      end else begin
         $display("** multi_encoding_value_scan_top: FAILED **");
      end
      $finish;
   end

endmodule
